### hdl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; every other file refers to it by scoped name.
package mer_pkg;

  localparam int COORD_W         = 13;
  localparam int CENTER_W        = 11;
  localparam int COLOR_W         = 8;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int PIXELS_PER_STEP = 4;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd15;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIUS_X    = 3'd0,
    REG_RADIUS_Y    = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_PIXEL_COLOR = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_RESTART,
    MODE_REGION1,
    MODE_REGION2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TERM,
    ST_TERM2,
    ST_DEC,
    ST_FIN
  } core_state_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  typedef struct packed {
    logic               valid;
    logic               fin;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } job_t;

endpackage

### hdl/mer_if.sv
// Channel interfaces: step requests, pixel results and register writes.
// Depends on mer_pkg for field widths.
interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mer_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mer_pkg::COORD_W-1:0]  pixel_x;
  logic signed [mer_pkg::COORD_W-1:0]  pixel_y;
  logic        [mer_pkg::COLOR_W-1:0]  color;
  logic                                last_of_four;
  logic                                done_res;

  modport source (output valid, output pixel_x, output pixel_y, output color,
                  output last_of_four, output done_res, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input color,
                  input last_of_four, input done_res, output ready);
endinterface

interface mer_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mer_pkg::CFG_INDEX_W-1:0]     index;
  logic [mer_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level: front end, step engine, emitter.
// Engine states: a restart runs multiply, term, finish; region one adds a decision
// update and region two also a second term. One command at a time; the engine can start
// the next while the emitter sends a step's pixels. An idle step is popped and dropped.
// Reset (synchronous, active low) clears queue, engine and emitter control and loads
// register defaults; no clearing pass, the block takes items from the next cycle.
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  mer_in_if.sink     in_ch,
  mer_out_if.source  out_ch,
  mer_cfg_if.sink    cfg_ch
);

  mer_pkg::cmd_slot_t             head;
  mer_pkg::job_t                  job;
  logic                           pop;
  logic                           emit_ready;
  logic [RADIUS_BITS-1:0]         rx, ry;
  logic [mer_pkg::CENTER_W-1:0]   cx, cy;
  logic [mer_pkg::COLOR_W-1:0]    color;

  mer_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .pop    (pop),
    .head   (head),
    .rx     (rx),
    .ry     (ry),
    .cx     (cx),
    .cy     (cy),
    .color  (color)
  );

  mer_core #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx         (rx),
    .ry         (ry),
    .head       (head),
    .pop        (pop),
    .job        (job),
    .emit_ready (emit_ready)
  );

  mer_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .emit_ready (emit_ready),
    .cx         (cx),
    .cy         (cy),
    .color      (color),
    .out_ch     (out_ch)
  );

endmodule

### hdl/mer_front.sv
// Front end: configuration registers, step request intake and a two-entry
// command queue. Depends on mer_pkg and mer_if.
module mer_front #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mer_in_if.sink                         in_ch,
  mer_cfg_if.sink                        cfg_ch,
  input  logic                           pop,
  output mer_pkg::cmd_slot_t             head,
  output logic [RADIUS_BITS-1:0]         rx,
  output logic [RADIUS_BITS-1:0]         ry,
  output logic [mer_pkg::CENTER_W-1:0]   cx,
  output logic [mer_pkg::CENTER_W-1:0]   cy,
  output logic [mer_pkg::COLOR_W-1:0]    color
);

  mer_pkg::cmd_t                  slot_r [2];
  logic                           wr_ptr_r;
  logic                           rd_ptr_r;
  logic [1:0]                     count_r;
  logic [RADIUS_BITS-1:0]         rx_r;
  logic [RADIUS_BITS-1:0]         ry_r;
  logic [mer_pkg::CENTER_W-1:0]   cx_r;
  logic [mer_pkg::CENTER_W-1:0]   cy_r;
  logic [mer_pkg::COLOR_W-1:0]    color_r;
  logic                           push;
  logic                           cfg_wr;

  assign in_ch.ready  = !count_r[1];
  assign cfg_ch.ready = 1'b1;
  assign push         = in_ch.valid && in_ch.ready;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = slot_r[rd_ptr_r];

  assign rx    = rx_r;
  assign ry    = ry_r;
  assign cx    = cx_r;
  assign cy    = cy_r;
  assign color = color_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_ch.restart ? mer_pkg::CMD_RESTART : mer_pkg::CMD_ADVANCE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      rx_r     <= '0;
      ry_r     <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= mer_pkg::COLOR_RESET;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
      if (cfg_wr) begin
        case (cfg_ch.index)
          mer_pkg::REG_RADIUS_X:    rx_r    <= cfg_ch.data[RADIUS_BITS-1:0];
          mer_pkg::REG_RADIUS_Y:    ry_r    <= cfg_ch.data[RADIUS_BITS-1:0];
          mer_pkg::REG_CENTER_X:    cx_r    <= cfg_ch.data[mer_pkg::CENTER_W-1:0];
          mer_pkg::REG_CENTER_Y:    cy_r    <= cfg_ch.data[mer_pkg::CENTER_W-1:0];
          mer_pkg::REG_PIXEL_COLOR: color_r <= cfg_ch.data[mer_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### hdl/mer_core.sv
// Step engine: midpoint decision update over a short multiply/add sequence,
// hands each step's offsets to the pixel emitter. Depends on mer_pkg.
module mer_core #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [RADIUS_BITS-1:0] rx,
  input  logic [RADIUS_BITS-1:0] ry,
  input  mer_pkg::cmd_slot_t     head,
  output logic                   pop,
  output mer_pkg::job_t          job,
  input  logic                   emit_ready
);

  localparam int POS_W  = RADIUS_BITS + 1;
  localparam int TERM_W = 3 * RADIUS_BITS + 4;
  localparam int DEC_W  = 4 * RADIUS_BITS + 8;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int U_W    = 2 * RADIUS_BITS + 2;
  localparam int UU_W   = 4 * RADIUS_BITS + 4;
  localparam int W2_W   = 4 * RADIUS_BITS;
  localparam int RXW_W  = 3 * RADIUS_BITS;

  mer_pkg::core_state_t       state_r, state_nxt;
  mer_pkg::mode_t             mode_r;
  logic                       active_r;
  logic                       r2_r;
  logic                       sel_r;
  logic [POS_W-1:0]           x_r, y_r;
  logic signed [TERM_W-1:0]   xt_r, yt_r;
  logic signed [DEC_W-1:0]    dec_r;
  logic [SQ_W-1:0]            rx2_r, ry2_r, w_r;
  logic [U_W-1:0]             u_r;
  logic signed [U_W-1:0]      v_r;
  logic [UU_W-1:0]            uu_r, vv_r;
  logic [W2_W-1:0]            ww_r;
  logic [RXW_W-1:0]           rxw_r;

  logic [POS_W:0]             a_odd;
  logic signed [POS_W:0]      b_s;
  logic signed [U_W-1:0]      v_prod;
  logic signed [UU_W-1:0]     vv_prod;
  logic signed [TERM_W-1:0]   xt_inc, yt_dec;
  logic [DEC_W-1:0]           dec_entry, dec_start;
  logic [DEC_W-1:0]           xt_e, yt_e, rx2_e, ry2_e, dsum;
  logic signed [DEC_W-1:0]    dec_upd;
  logic                       dec_pos;
  logic                       region1_ok;
  logic                       more;

  // offsets for the region two entry: (2x+1) and (y-1)
  assign a_odd   = {x_r, 1'b1};
  assign b_s     = $signed({1'b0, y_r}) - $signed((POS_W+1)'(1));
  assign v_prod  = U_W'($signed({1'b0, rx})) * U_W'(b_s);
  assign vv_prod = UU_W'(v_r) * UU_W'(v_r);

  assign xt_inc = xt_r + $signed(TERM_W'({ry2_r, 1'b0}));
  assign yt_dec = yt_r - $signed(TERM_W'({rx2_r, 1'b0}));

  assign dec_entry = DEC_W'(uu_r) + DEC_W'({vv_r, 2'b00}) - DEC_W'({ww_r, 2'b00});
  assign dec_start = DEC_W'({ry2_r, 2'b00}) - DEC_W'({rxw_r, 2'b00}) + DEC_W'(rx2_r);

  assign xt_e  = {{(DEC_W-TERM_W){xt_r[TERM_W-1]}}, xt_r};
  assign yt_e  = {{(DEC_W-TERM_W){yt_r[TERM_W-1]}}, yt_r};
  assign rx2_e = DEC_W'(rx2_r);
  assign ry2_e = DEC_W'(ry2_r);

  always_comb begin
    if (mode_r == mer_pkg::MODE_REGION1) begin
      dsum = ry2_e + xt_e - (sel_r ? '0 : yt_e);
    end else begin
      dsum = rx2_e - yt_e + (sel_r ? '0 : xt_e);
    end
  end

  assign dec_upd    = dec_r + $signed({dsum[DEC_W-3:0], 2'b00});
  assign dec_pos    = !dec_r[DEC_W-1] && (dec_r != '0);
  assign region1_ok = !r2_r && (xt_r < yt_r);
  assign more       = region1_ok || (y_r != '0);

  assign job.fin = !more;
  assign job.dx  = mer_pkg::COORD_W'(x_r);
  assign job.dy  = mer_pkg::COORD_W'(y_r);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    job.valid = 1'b0;
    case (state_r)
      mer_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd == mer_pkg::CMD_RESTART || active_r) begin
            state_nxt = mer_pkg::ST_MUL;
          end
        end
      end
      mer_pkg::ST_MUL: state_nxt = mer_pkg::ST_TERM;
      mer_pkg::ST_TERM: begin
        case (mode_r)
          mer_pkg::MODE_RESTART: state_nxt = mer_pkg::ST_FIN;
          mer_pkg::MODE_REGION1: state_nxt = mer_pkg::ST_DEC;
          default:               state_nxt = mer_pkg::ST_TERM2;
        endcase
      end
      mer_pkg::ST_TERM2: state_nxt = mer_pkg::ST_DEC;
      mer_pkg::ST_DEC:   state_nxt = mer_pkg::ST_FIN;
      mer_pkg::ST_FIN: begin
        job.valid = 1'b1;
        if (emit_ready) begin
          state_nxt = mer_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mer_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mer_pkg::ST_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mer_pkg::ST_TERM && mode_r == mer_pkg::MODE_RESTART) begin
        active_r <= 1'b1;
      end else if (state_r == mer_pkg::ST_FIN && emit_ready) begin
        active_r <= more;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mer_pkg::ST_IDLE: begin
        rx2_r <= SQ_W'(rx) * SQ_W'(rx);
        ry2_r <= SQ_W'(ry) * SQ_W'(ry);
        w_r   <= SQ_W'(rx) * SQ_W'(ry);
        u_r   <= U_W'(ry) * U_W'(a_odd);
        v_r   <= v_prod;
        if (head.cmd == mer_pkg::CMD_RESTART) begin
          mode_r <= mer_pkg::MODE_RESTART;
        end else if (region1_ok) begin
          mode_r <= mer_pkg::MODE_REGION1;
        end else begin
          mode_r <= mer_pkg::MODE_REGION2;
        end
      end
      mer_pkg::ST_MUL: begin
        uu_r  <= UU_W'(u_r) * UU_W'(u_r);
        vv_r  <= vv_prod;
        ww_r  <= W2_W'(w_r) * W2_W'(w_r);
        rxw_r <= RXW_W'(rx) * RXW_W'(w_r);
      end
      mer_pkg::ST_TERM: begin
        case (mode_r)
          mer_pkg::MODE_RESTART: begin
            x_r   <= '0;
            y_r   <= POS_W'(ry);
            xt_r  <= '0;
            yt_r  <= $signed(TERM_W'({rxw_r, 1'b0}));
            dec_r <= $signed(dec_start);
            r2_r  <= 1'b0;
          end
          mer_pkg::MODE_REGION1: begin
            sel_r <= dec_r[DEC_W-1];
            x_r   <= x_r + POS_W'(1);
            xt_r  <= xt_inc;
            if (!dec_r[DEC_W-1]) begin
              y_r  <= y_r - POS_W'(1);
              yt_r <= yt_dec;
            end
          end
          default: begin
            if (!r2_r) begin
              dec_r <= $signed(dec_entry);
              r2_r  <= 1'b1;
            end
            y_r  <= y_r - POS_W'(1);
            yt_r <= yt_dec;
          end
        endcase
      end
      mer_pkg::ST_TERM2: begin
        sel_r <= dec_pos;
        if (!dec_pos) begin
          x_r  <= x_r + POS_W'(1);
          xt_r <= xt_inc;
        end
      end
      mer_pkg::ST_DEC: dec_r <= dec_upd;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("command popped from an empty queue");

  a_idle_step_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mer_pkg::ST_IDLE && head.valid && head.cmd == mer_pkg::CMD_ADVANCE
     && !active_r) |=> (state_r == mer_pkg::ST_IDLE))
    else $error("step started while no ellipse is active");

  a_restart_activates: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mer_pkg::ST_TERM && mode_r == mer_pkg::MODE_RESTART) |=> active_r)
    else $error("restart did not mark the ellipse active");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mer_pkg::ST_FIN && !emit_ready) |=>
      (state_r == mer_pkg::ST_FIN && $stable(x_r) && $stable(y_r)))
    else $error("step offsets changed while waiting for the emitter");
`endif

endmodule

### hdl/mer_emit.sv
// Pixel emitter: expands one step into its four mirrored pixels on the
// result channel and holds them until taken. Depends on mer_pkg and mer_if.
module mer_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mer_pkg::job_t                 job,
  output logic                          emit_ready,
  input  logic [mer_pkg::CENTER_W-1:0]  cx,
  input  logic [mer_pkg::CENTER_W-1:0]  cy,
  input  logic [mer_pkg::COLOR_W-1:0]   color,
  mer_out_if.source                     out_ch
);

  localparam int K_W = $clog2(mer_pkg::PIXELS_PER_STEP);
  localparam logic [K_W-1:0] K_LAST = K_W'(mer_pkg::PIXELS_PER_STEP - 1);

  mer_pkg::job_t                  job_r;
  logic [mer_pkg::COORD_W-1:0]    cx_r, cy_r;
  logic [mer_pkg::COLOR_W-1:0]    color_r;
  logic                           busy_r;
  logic [K_W-1:0]                 k_r;
  logic                           xfer;
  logic                           last;
  logic                           load;
  logic                           neg_x, neg_y;

  assign xfer       = out_ch.valid && out_ch.ready;
  assign last       = (k_r == K_LAST);
  assign emit_ready = !busy_r || (xfer && last);
  assign load       = job.valid && emit_ready;

  // order: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
  assign neg_x = k_r[0] ^ k_r[1];
  assign neg_y = k_r[1];

  assign out_ch.valid        = busy_r;
  assign out_ch.pixel_x      = $signed(neg_x ? cx_r - job_r.dx : cx_r + job_r.dx);
  assign out_ch.pixel_y      = $signed(neg_y ? cy_r - job_r.dy : cy_r + job_r.dy);
  assign out_ch.color        = color_r;
  assign out_ch.last_of_four = last;
  assign out_ch.done_res     = job_r.fin;

  always_ff @(posedge clk) begin
    if (load) begin
      job_r   <= job;
      cx_r    <= mer_pkg::COORD_W'(cx);
      cy_r    <= mer_pkg::COORD_W'(cy);
      color_r <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (xfer) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      k_r <= k_r + K_W'(1);
    end
  end

endmodule
